FILE: hw/rtl/dcat_pkg.sv
package dcat_pkg;

  localparam int unsigned MaxEntriesDefault = 16;

  localparam int unsigned CmdW     = 1;
  localparam int unsigned ChW      = 16;
  localparam int unsigned DlyW     = 16;
  localparam int unsigned PwmW     = 16;
  localparam int unsigned PctW     = 14;
  localparam int unsigned StatusW  = 3;

  localparam logic [CmdW-1:0] CMD_ARM  = 1'b0;
  localparam logic [CmdW-1:0] CMD_TICK = 1'b1;

  localparam logic [StatusW-1:0] ST_FIRED     = 3'd0;
  localparam logic [StatusW-1:0] ST_ARMED     = 3'd1;
  localparam logic [StatusW-1:0] ST_UPDATED   = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_TICK_DONE = 3'd4;

  typedef struct packed {
    logic [ChW-1:0]  channel;
    logic [DlyW-1:0] remaining;
    logic [PwmW-1:0] pwm;
    logic [PctW-1:0] percent;
  } entry_t;

  // per-slot control: shift from right neighbor, or load from the broadcast bus
  typedef struct packed {
    logic shift;
    logic load;
  } slot_ctrl_t;

endpackage

FILE: hw/rtl/dcat_in_if.sv
interface dcat_in_if
  import dcat_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [ChW-1:0]  channel_id;
  logic [DlyW-1:0] delay_ms;
  logic [PwmW-1:0] pwm_value;
  logic [PctW-1:0] percent_hundredths;
  logic [DlyW-1:0] elapsed_ms;

  modport source (
    output valid, cmd, channel_id, delay_ms, pwm_value, percent_hundredths, elapsed_ms,
    input  ready
  );

  modport sink (
    input  valid, cmd, channel_id, delay_ms, pwm_value, percent_hundredths, elapsed_ms,
    output ready
  );
endinterface

FILE: hw/rtl/dcat_out_if.sv
interface dcat_out_if
  import dcat_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ChW-1:0]     fired_channel;
  logic [PwmW-1:0]    fired_pwm;
  logic [PctW-1:0]    fired_percent;
  logic               last;

  modport source (
    output valid, status, fired_channel, fired_pwm, fired_percent, last,
    input  ready
  );

  modport sink (
    input  valid, status, fired_channel, fired_pwm, fired_percent, last,
    output ready
  );
endinterface

FILE: hw/rtl/dcat_slot.sv
module dcat_slot
  import dcat_pkg::*;
(
  input  logic           clk_i,
  input  slot_ctrl_t     ctrl_i,
  input  entry_t         load_i,
  input  entry_t         next_i,
  input  logic [ChW-1:0] ch_i,
  output entry_t         entry_o,
  output logic           match_o
);

  entry_t entry_q;

  // load wins over shift, so the tail slot can take the write-back
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.channel == ch_i);

endmodule

FILE: hw/rtl/delayed_channel_action_timers.sv
// arm beat: one result beat, registered, visible the cycle after acceptance
// tick beat: the walk moves one live entry per cycle through the slot chain head, held
//   only while a fired entry waits for the output register, then adds the tick-done beat
// one item at a time; a new item is taken once the walk is over and the output register is free:
//   after a tick once the walk has returned to idle, the next cycle after an arm
// reset (async, active low) empties the table and drops any pending output beat
module delayed_channel_action_timers
  import dcat_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  dcat_in_if.sink     in_i,
  dcat_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;      // live entries, held in slots 0..cnt-1
  logic [CntW-1:0] steps_q, steps_d;  // entries still to visit in this tick
  logic [DlyW-1:0] el_q, el_d;        // elapsed time of the tick in progress

  entry_t     slot_q    [MAX_ENTRIES];
  slot_ctrl_t slot_ctrl [MAX_ENTRIES];
  logic       slot_match[MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit;
  entry_t     load_bus;
  entry_t     head;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q, emit_status;
  logic [ChW-1:0]     out_ch_q;
  logic [PwmW-1:0]    out_pwm_q;
  logic [PctW-1:0]    out_pct_q;
  logic               out_last_q, emit_last;
  logic               emit;
  entry_t             emit_entry;

  logic out_free;
  logic accept;
  logic fire;
  logic any_hit;

  // ---------------------------------------------------------------------------
  // slot chain: each slot hands its entry to the left neighbor on a shift;
  // the rightmost slot just holds its own contents
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_slot
    entry_t next_entry;
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign next_entry = slot_q[k];
    end else begin : g_mid
      assign next_entry = slot_q[k+1];
    end

    dcat_slot u_slot (
      .clk_i   (clk_i),
      .ctrl_i  (slot_ctrl[k]),
      .load_i  (load_bus),
      .next_i  (next_entry),
      .ch_i    (in_i.channel_id),
      .entry_o (slot_q[k]),
      .match_o (slot_match[k])
    );

    // only live slots may claim a channel match
    assign hit[k] = slot_match[k] && (CntW'(k) < cnt_q);
  end

  assign any_hit  = |hit;
  assign head     = slot_q[0];
  assign fire     = (head.remaining < el_q);   // equal delay does not fire
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // controller
  // a tick rotates the chain once: every step the head leaves slot 0; a kept
  // entry is written back at the tail of the live region, a fired one is dropped
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    el_d        = el_q;
    emit        = 1'b0;
    emit_status = ST_TICK_DONE;
    emit_last   = 1'b1;
    emit_entry  = '0;
    load_bus.channel   = in_i.channel_id;
    load_bus.remaining = in_i.delay_ms;
    load_bus.pwm       = in_i.pwm_value;
    load_bus.percent   = in_i.percent_hundredths;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      slot_ctrl[k] = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_TICK) begin
            state_d = S_WALK;
            steps_d = cnt_q;
            el_d    = in_i.elapsed_ms;
          end else begin
            emit = 1'b1;
            if (any_hit) begin
              // same channel already pending: overwrite in place
              emit_status = ST_UPDATED;
              for (int k = 0; k < MAX_ENTRIES; k++) begin
                slot_ctrl[k].load = hit[k];
              end
            end else if (cnt_q < CntMax) begin
              // append behind the last live entry
              emit_status = ST_ARMED;
              cnt_d       = cnt_q + 1'b1;
              for (int k = 0; k < MAX_ENTRIES; k++) begin
                slot_ctrl[k].load = (CntW'(k) == cnt_q);
              end
            end else begin
              emit_status = ST_FULL;
            end
          end
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!fire || out_free) begin
          steps_d = steps_q - 1'b1;
          for (int k = 0; k < MAX_ENTRIES; k++) begin
            slot_ctrl[k].shift = 1'b1;
          end
          if (fire) begin
            emit        = 1'b1;
            emit_status = ST_FIRED;
            emit_last   = 1'b0;
            emit_entry  = head;
            cnt_d       = cnt_q - 1'b1;
          end else begin
            load_bus.channel   = head.channel;
            load_bus.remaining = head.remaining - el_q;
            load_bus.pwm       = head.pwm;
            load_bus.percent   = head.percent;
            for (int k = 0; k < MAX_ENTRIES; k++) begin
              slot_ctrl[k].load = (CntW'(k) == cnt_q - 1'b1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q <= el_d;
  end

  // ---------------------------------------------------------------------------
  // output register: one result beat parked here while the chain moves on
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= emit_status;
      out_ch_q     <= emit_entry.channel;
      out_pwm_q    <= emit_entry.pwm;
      out_pct_q    <= emit_entry.percent;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.fired_channel = out_ch_q;
  assign out_o.fired_pwm     = out_pwm_q;
  assign out_o.fired_percent = out_pct_q;
  assign out_o.last          = out_last_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("entry count above table size");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (steps_q <= cnt_q))
    else $error("walk steps exceed live entries");

  a_fire_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && steps_q != '0 && fire && out_free)
      |=> (cnt_q == $past(cnt_q) - 1'b1) && out_valid_q && !out_last_q)
    else $error("fired entry not removed or not reported");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && steps_q == '0 && out_free)
      |=> (state_q == S_IDLE) && out_valid_q && out_last_q
          && (out_status_q == ST_TICK_DONE))
    else $error("tick walk did not close with a tick-done beat");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !in_i.ready)
    else $error("input taken during a tick walk");

endmodule

FILE: verif/delayed_channel_action_timers_tb.sv
module delayed_channel_action_timers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcat_pkg::*;

  // table depth of the instance, also the depth of the local timer table
  localparam int unsigned TableDepth   = MaxEntriesDefault;
  localparam int unsigned RandomItems  = 196;
  localparam int unsigned PoolSize     = 24;
  // a full tick is 17 beats, each can wait out a long receiver stall
  localparam int unsigned IdleLimit    = 2000;
  // the long receiver hold-off starts once this many beats have been taken
  localparam int unsigned HoldAtBeat   = 150;
  localparam int unsigned HoldCycles   = 400;
  // extra cycles so anything still in flight can finish
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 50;

  // one command to the timer block
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [ChW-1:0]  channel;
    logic [DlyW-1:0] delay;
    logic [PwmW-1:0] pwm;
    logic [PctW-1:0] percent;
    logic [DlyW-1:0] elapsed;
  } timer_cmd_t;

  // one result beat, field order matches the output interface
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ChW-1:0]     channel;
    logic [PwmW-1:0]    pwm;
    logic [PctW-1:0]    percent;
    logic               last;
  } timer_beat_t;

  // receiver behavior, picked anew at random
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_STARVED
  } rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dcat_in_if  in_bus ();
  dcat_out_if out_bus ();

  delayed_channel_action_timers #(
    .MAX_ENTRIES (TableDepth)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting to be offered, and beats the timer table says must come
  timer_cmd_t  cmd_queue[$];
  timer_beat_t due_beats[$];

  // local copy of the timer table, entries below live_count are valid
  logic [ChW-1:0]  tbl_channel   [TableDepth];
  logic [DlyW-1:0] tbl_remaining [TableDepth];
  logic [PwmW-1:0] tbl_pwm       [TableDepth];
  logic [PctW-1:0] tbl_percent   [TableDepth];
  int unsigned     live_count = 0;

  logic [ChW-1:0] id_pool [PoolSize];

  // what the run went through
  int unsigned n_armed = 0, n_updated = 0, n_dropped = 0, n_ticks = 0;
  int unsigned n_fired = 0, most_fired = 0;
  int unsigned items_taken = 0, beats_seen = 0, err_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MaxPrinted)
      $display("%0t ns: beat %0d: %s is %0h, expected %0h", $time, beats_seen, what, got,
               want);
    err_count++;
  endtask

  // advance the local timer table by one accepted command and queue its beats
  task automatic apply_to_timer_table(input timer_cmd_t c);
    timer_beat_t b;
    int unsigned idx;
    int unsigned fired_here;
    bit          hit;
    b = '0;
    b.last = 1'b1;
    if (c.cmd == CMD_ARM) begin
      hit = 1'b0;
      for (idx = 0; idx < live_count; idx++) begin
        if (!hit && tbl_channel[idx] == c.channel) begin
          tbl_remaining[idx] = c.delay;
          tbl_pwm[idx]       = c.pwm;
          tbl_percent[idx]   = c.percent;
          hit = 1'b1;
        end
      end
      if (hit) begin
        b.status = ST_UPDATED;
        n_updated++;
      end else if (live_count < TableDepth) begin
        tbl_channel[live_count]   = c.channel;
        tbl_remaining[live_count] = c.delay;
        tbl_pwm[live_count]       = c.pwm;
        tbl_percent[live_count]   = c.percent;
        live_count++;
        b.status = ST_ARMED;
        n_armed++;
      end else begin
        b.status = ST_FULL;
        n_dropped++;
      end
      due_beats.push_back(b);
    end else begin
      // walk in order; a fired entry closes the gap, so idx stays put
      idx = 0;
      fired_here = 0;
      while (idx < live_count) begin
        if (tbl_remaining[idx] < c.elapsed) begin
          b.status  = ST_FIRED;
          b.channel = tbl_channel[idx];
          b.pwm     = tbl_pwm[idx];
          b.percent = tbl_percent[idx];
          b.last    = 1'b0;
          due_beats.push_back(b);
          for (int unsigned j = idx; j + 1 < live_count; j++) begin
            tbl_channel[j]   = tbl_channel[j + 1];
            tbl_remaining[j] = tbl_remaining[j + 1];
            tbl_pwm[j]       = tbl_pwm[j + 1];
            tbl_percent[j]   = tbl_percent[j + 1];
          end
          live_count--;
          fired_here++;
        end else begin
          tbl_remaining[idx] = tbl_remaining[idx] - c.elapsed;
          idx++;
        end
      end
      b = '0;
      b.status = ST_TICK_DONE;
      b.last   = 1'b1;
      due_beats.push_back(b);
      n_ticks++;
      n_fired += fired_here;
      if (fired_here > most_fired) most_fired = fired_here;
    end
  endtask

  // ignored fields get random content so the block is seen to ignore them
  function automatic timer_cmd_t make_arm(input logic [ChW-1:0] ch,
                                          input logic [DlyW-1:0] dly,
                                          input logic [PwmW-1:0] pwm,
                                          input logic [PctW-1:0] pct);
    timer_cmd_t c;
    c.cmd     = CMD_ARM;
    c.channel = ch;
    c.delay   = dly;
    c.pwm     = pwm;
    c.percent = pct;
    c.elapsed = 16'($urandom);
    return c;
  endfunction

  function automatic timer_cmd_t make_tick(input logic [DlyW-1:0] el,
                                           input logic [ChW-1:0] ch);
    timer_cmd_t c;
    c.cmd     = CMD_TICK;
    c.channel = ch;
    c.delay   = 16'($urandom);
    c.pwm     = 16'($urandom);
    c.percent = 14'($urandom);
    c.elapsed = el;
    return c;
  endfunction

  // random traffic: channel ids mostly from a small pool, so updates and a
  // full table both happen, and tick lengths on the scale of the delays
  task automatic queue_random_items(input int unsigned count);
    logic [DlyW-1:0] dly;
    logic [DlyW-1:0] el;
    logic [ChW-1:0]  ch;
    logic [PctW-1:0] pct;
    int unsigned     pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      dly = '0;
      else if (pick < 20) dly = 16'($urandom);
      else if (pick < 40) dly = 16'($urandom_range(0, 2000));
      else                dly = 16'($urandom_range(0, 500));
      pick = $urandom_range(0, 99);
      if (pick < 10)      el = '0;
      else if (pick < 18) el = '1;
      else if (pick < 30) el = 16'($urandom);
      else if (pick < 55) el = 16'($urandom_range(0, 50));
      else                el = 16'($urandom_range(0, 400));
      pick = $urandom_range(0, 99);
      if (pick < 10)      pct = '0;
      else if (pick < 20) pct = 14'($urandom_range(10000, 16383));
      else                pct = 14'($urandom_range(0, 10000));
      if ($urandom_range(0, 99) < 80) ch = id_pool[$urandom_range(0, PoolSize - 1)];
      else                            ch = 16'($urandom);
      if ($urandom_range(0, 99) < 62) begin
        cmd_queue.push_back(make_arm(ch, dly, 16'($urandom), pct));
      end else begin
        cmd_queue.push_back(make_tick(el, 16'($urandom)));
      end
    end
  endtask

  // hold the sender until every queued command is in and every beat is out
  task automatic wait_for_drain();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_bus.valid || due_beats.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length separated by random gaps, fed by cmd_queue
  // ---------------------------------------------------------------------------
  timer_cmd_t  on_offer;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    logic       offer;
    timer_cmd_t nxt;
    if (rst_n) begin
      offer = in_bus.valid;
      nxt   = on_offer;
      if (in_bus.valid && in_bus.ready) begin
        apply_to_timer_table(on_offer);
        items_taken++;
        offer = 1'b0;
      end
      // a beat that stays up back to back is driven by this single assignment
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() != 0) begin
          nxt   = cmd_queue.pop_front();
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long stretch with no gaps at all
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(0, 12);
          end
        end
      end
      on_offer <= nxt;
      in_bus.valid              <= offer;
      in_bus.cmd                <= nxt.cmd;
      in_bus.channel_id         <= nxt.channel;
      in_bus.delay_ms           <= nxt.delay;
      in_bus.pwm_value          <= nxt.pwm;
      in_bus.percent_hundredths <= nxt.percent;
      in_bus.elapsed_ms         <= nxt.elapsed;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each beat against the oldest due beat, drives ready
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_STEADY;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  always @(posedge clk) begin
    logic        rdy;
    timer_beat_t got;
    timer_beat_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.status, out_bus.fired_channel, out_bus.fired_pwm,
               out_bus.fired_percent, out_bus.last};
        beats_seen++;
        if (due_beats.size() == 0) begin
          report_mismatch("beat with nothing due, status", 32'(got.status), '0);
        end else begin
          want = due_beats.pop_front();
          if (got.status !== want.status)   report_mismatch("status", 32'(got.status),
                                                            32'(want.status));
          if (got.channel !== want.channel) report_mismatch("fired_channel", 32'(got.channel),
                                                            32'(want.channel));
          if (got.pwm !== want.pwm)         report_mismatch("fired_pwm", 32'(got.pwm),
                                                            32'(want.pwm));
          if (got.percent !== want.percent) report_mismatch("fired_percent", 32'(got.percent),
                                                            32'(want.percent));
          if (got.last !== want.last)       report_mismatch("last", 32'(got.last),
                                                            32'(want.last));
        end
        // long hold-off while the sender keeps offering, so the block backs up
        if (!held_once && beats_seen == HoldAtBeat) begin
          hold_left = HoldCycles;
          held_once = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_STEADY: rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          default:   rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_bus.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no beat moves on either side for too long
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: no beat moved for %0d cycles, %0d beats still due", $time,
                 idle_cycles, due_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid              = 1'b0;
    in_bus.cmd                = CMD_ARM;
    in_bus.channel_id         = '0;
    in_bus.delay_ms           = '0;
    in_bus.pwm_value          = '0;
    in_bus.percent_hundredths = '0;
    in_bus.elapsed_ms         = '0;
    out_bus.ready             = 1'b0;
    on_offer                  = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the table: ids 0 up to ffff, delays 0 up to 1400 and one at ffff,
    // pwm spans both extremes, one percentage at 10000 and one above it
    for (int unsigned i = 0; i < TableDepth; i++) begin
      cmd_queue.push_back(make_arm(
        16'(i * 16'h1111),
        (i == TableDepth - 1) ? 16'hFFFF : 16'(i * 100),
        ~16'(i * 16'h1111),
        (i == TableDepth - 1) ? 14'h3FFF : (i == TableDepth - 2) ? 14'd10000 : 14'(i * 600)));
    end
    cmd_queue.push_back(make_arm(16'h1234, 16'd7, 16'h0001, 14'd1));  // table full, dropped
    cmd_queue.push_back(make_arm(16'h3333, 16'd5, 16'hABCD, 14'd1));  // update in place
    cmd_queue.push_back(make_tick(16'd0, 16'hFFFF));     // zero elapsed: nothing moves
    cmd_queue.push_back(make_tick(16'd100, 16'h0000));   // delay 100 equals elapsed, stays
    cmd_queue.push_back(make_tick(16'd1, 16'h0000));     // ...and fires now
    cmd_queue.push_back(make_arm(16'h1234, 16'hFFFF, 16'h8000, 14'd9999));
    cmd_queue.push_back(make_tick(16'hFFFF, 16'h1234));  // flushes all but the ffff delay
    cmd_queue.push_back(make_tick(16'd1, 16'hFFFF));     // last entry goes
    wait_for_drain();

    for (int unsigned p = 0; p < PoolSize; p++) id_pool[p] = 16'($urandom);
    queue_random_items(RandomItems / 2);
    // sender pauses until the block has handed back everything
    wait_for_drain();
    queue_random_items(RandomItems - RandomItems / 2);
    wait_for_drain();
    repeat (SettleCycles) @(negedge clk);

    $display("covered %0d commands: %0d new arms, %0d updates, %0d drops on a full table,",
             items_taken, n_armed, n_updated, n_dropped);
    $display("%0d ticks firing %0d entries (up to %0d in one tick), %0d beats checked",
             n_ticks, n_fired, most_fired, beats_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dcat_pkg.sv
hw/rtl/dcat_in_if.sv
hw/rtl/dcat_out_if.sv
hw/rtl/dcat_slot.sv
hw/rtl/delayed_channel_action_timers.sv
verif/delayed_channel_action_timers_tb.sv
